>>> rtl/core/a85_pkg.sv
// Shared types and constants for the ASCII85 stream decoder.
// No dependencies; all other files in rtl/core refer to it by scoped names.
`timescale 1ns / 1ps

package a85_pkg;

  localparam logic       KIND_CHAR  = 1'b0;
  localparam logic       KIND_END   = 1'b1;

  localparam logic [7:0] DIGIT_LOW  = 8'd33;   // '!'
  localparam logic [7:0] DIGIT_HIGH = 8'd117;  // 'u'
  localparam logic [7:0] ZERO_CHAR  = 8'd122;  // 'z'
  localparam logic [7:0] SPACE_CHAR = 8'd32;
  localparam logic [7:0] DEL_CHAR   = 8'd127;
  localparam logic [7:0] BASE85     = 8'd85;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    ST_DATA      = 2'd0,
    ST_END_EMPTY = 2'd1,
    ST_INVALID   = 2'd2,
    ST_LONE      = 2'd3
  } status_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    status_t    status;
    logic       end_of_stream;
    logic       last;
  } out_item_t;

  // One queued request: a word and how many results it yields.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    status_t     status;
    logic        eos;
  } job_t;

  // 85^(5-n) for padding a partial group of n characters with 'u'.
  function automatic logic [19:0] pad_mult(input logic [2:0] n);
    logic [19:0] m;
    unique case (n)
      3'd2:    m = 20'd614125;
      3'd3:    m = 20'd7225;
      3'd4:    m = 20'd85;
      default: m = 20'd1;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/core/a85_front.sv
// Front end: accepts characters, builds base-85 groups and classifies requests.
// Depends on a85_pkg; pushes job_t requests into a85_job_queue.
`timescale 1ns / 1ps

module a85_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  a85_pkg::in_item_t in_data,
  output logic              push,
  output a85_pkg::job_t     push_job,
  input  logic              full
);

  logic [2:0]  group_count, group_count_next;
  logic [31:0] group_value, group_value_next;
  logic        halted, halted_next;

  logic        accept;
  logic [7:0]  c;
  logic [38:0] acc_prod;
  logic [31:0] acc_value;
  logic [19:0] pmult;
  logic [51:0] pad_prod;
  logic [31:0] padded;

  assign in_stall = full;
  assign accept   = in_valid && !full;
  assign c        = in_data.char_code;

  assign acc_prod  = 39'(group_value) * 39'(a85_pkg::BASE85);
  assign acc_value = acc_prod[31:0] + {24'd0, c - a85_pkg::DIGIT_LOW};
  assign pmult     = a85_pkg::pad_mult(group_count);
  assign pad_prod  = 52'(group_value) * 52'(pmult);
  assign padded    = pad_prod[31:0] + {12'd0, pmult} - 32'd1;

  always_comb begin
    group_count_next = group_count;
    group_value_next = group_value;
    halted_next      = halted;
    push             = 1'b0;
    push_job.word    = '0;
    push_job.nbytes  = 3'd1;
    push_job.status  = a85_pkg::ST_DATA;
    push_job.eos     = 1'b0;
    if (accept) begin
      if (in_data.kind == a85_pkg::KIND_END) begin
        push             = 1'b1;
        push_job.eos     = 1'b1;
        group_count_next = '0;
        group_value_next = '0;
        halted_next      = 1'b0;
        priority if (halted || group_count == 3'd0) begin
          push_job.status = a85_pkg::ST_END_EMPTY;
        end else if (group_count == 3'd1) begin
          push_job.status = a85_pkg::ST_LONE;
        end else begin
          push_job.word   = padded;
          push_job.nbytes = group_count - 3'd1;
        end
      end else if (!halted && c > a85_pkg::SPACE_CHAR && c < a85_pkg::DEL_CHAR) begin
        priority if (c == a85_pkg::ZERO_CHAR && group_count == 3'd0) begin
          push            = 1'b1;
          push_job.nbytes = 3'd4;
        end else if (c < a85_pkg::DIGIT_LOW || c > a85_pkg::DIGIT_HIGH) begin
          push            = 1'b1;
          push_job.status = a85_pkg::ST_INVALID;
          halted_next     = 1'b1;
        end else if (group_count == 3'd4) begin
          push             = 1'b1;
          push_job.word    = acc_value;
          push_job.nbytes  = 3'd4;
          group_count_next = '0;
          group_value_next = '0;
        end else begin
          group_count_next = group_count + 3'd1;
          group_value_next = acc_value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_count <= '0;
      group_value <= '0;
      halted      <= 1'b0;
    end else begin
      group_count <= group_count_next;
      group_value <= group_value_next;
      halted      <= halted_next;
    end
  end

endmodule

>>> rtl/core/a85_job_queue.sv
// Short request queue between the front end and the back end.
// Depends on a85_pkg for job_t and the queue depth.
`timescale 1ns / 1ps

module a85_job_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  a85_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output a85_pkg::job_t head_job,
  output logic          empty
);

  a85_pkg::job_t                entries [a85_pkg::QDEPTH];
  logic [a85_pkg::QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [a85_pkg::QPTR_W:0]     count;

  assign full     = count == (a85_pkg::QPTR_W+1)'(a85_pkg::QDEPTH);
  assign empty    = count == '0;
  assign head_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/core/a85_back.sv
// Back end: expands each request into result items, one per cycle unless stalled.
// Depends on a85_pkg; reads requests from a85_job_queue.
`timescale 1ns / 1ps

module a85_back (
  input  logic               clk,
  input  logic               rst,
  input  a85_pkg::job_t      head_job,
  input  logic               empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output a85_pkg::out_item_t out_data
);

  logic [1:0]         idx;
  logic               load;
  logic               is_final;
  logic [7:0]         sel_byte;
  a85_pkg::out_item_t result;

  assign load     = !out_valid || !out_stall;
  assign is_final = {1'b0, idx} == head_job.nbytes - 3'd1;
  assign pop      = load && !empty && is_final;

  always_comb begin
    unique case (idx)
      2'd0: sel_byte = head_job.word[31:24];
      2'd1: sel_byte = head_job.word[23:16];
      2'd2: sel_byte = head_job.word[15:8];
      2'd3: sel_byte = head_job.word[7:0];
    endcase
    result.data_byte     = (head_job.status == a85_pkg::ST_DATA) ? sel_byte : 8'd0;
    result.status        = head_job.status;
    result.end_of_stream = head_job.eos && is_final;
    result.last          = is_final;
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      out_data <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= !empty;
      if (!empty) begin
        idx <= is_final ? 2'd0 : idx + 2'd1;
      end
    end
  end

endmodule

>>> rtl/core/ascii85_stream_decoder_top.sv
// Top level of the ASCII85 stream decoder: front end, request queue, back end.
// Depends on a85_pkg, a85_front, a85_job_queue and a85_back.
//
// The decoder accepts one character or end item per cycle while the queue
// is not full, and delivers one result per cycle from a registered output
// while out_stall is low. Each input item is handled in the front end, where
// the base-85 multiply-accumulate (and, at end of stream, the padding
// multiply) completes in the cycle that accepts the item. A full group or a
// 'z' yields four results, so the sustained rate is bound by the back end at
// one result per cycle: five digits per four bytes, or four bytes per 'z'. A
// four-entry request queue absorbs the bursts; the input stalls only when it
// is full. Each result passes a queue entry and the output register.
`timescale 1ns / 1ps

module ascii85_stream_decoder_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  a85_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output a85_pkg::out_item_t out_data
);

  logic          push, full, pop, empty;
  a85_pkg::job_t push_job, head_job;

  a85_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .push_job (push_job),
    .full     (full)
  );

  a85_job_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head_job (head_job),
    .empty    (empty)
  );

  a85_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_job  (head_job),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> dv/testbench.sv
// Self-checking testbench for ascii85_stream_decoder_top: character streams with random
// idling on both channels, each result checked against a built-in ASCII85 decoder.
// Depends on a85_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module testbench;

  localparam int LIMIT  = 100000;
  localparam int SETTLE = 20;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  a85_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  a85_pkg::out_item_t out_data;

  logic steady = 1'b0;
  int   cycles = 0;

  class decode_tracker;
    a85_pkg::out_item_t due_results[$];
    logic [2:0]         group_count;
    logic [31:0]        group_value;
    logic               halted;
    int                 faults;
    int                 requests;
    int                 effective;
    int                 results;

    function new();
      clear();
      faults    = 0;
      requests  = 0;
      effective = 0;
      results   = 0;
    endfunction

    function void clear();
      group_count = '0;
      group_value = '0;
      halted      = 1'b0;
    endfunction

    function void add(logic [7:0] b, a85_pkg::status_t st, logic eos, logic lst);
      a85_pkg::out_item_t r;
      r.data_byte     = b;
      r.status        = st;
      r.end_of_stream = eos;
      r.last          = lst;
      due_results.push_back(r);
    endfunction

    function void note_request(a85_pkg::in_item_t req);
      logic [31:0] v;
      logic [7:0]  c;
      int          n;
      requests++;
      c = req.char_code;
      if (req.kind == a85_pkg::KIND_END) begin
        effective++;
        if (halted || group_count == 0) begin
          add(8'd0, a85_pkg::ST_END_EMPTY, 1'b1, 1'b1);
        end else if (group_count == 1) begin
          add(8'd0, a85_pkg::ST_LONE, 1'b1, 1'b1);
        end else begin
          // pad the partial group with 'u' digits
          v = group_value;
          n = group_count;
          for (int j = n; j < 5; j++)
            v = v * a85_pkg::BASE85 + (a85_pkg::DIGIT_HIGH - a85_pkg::DIGIT_LOW);
          for (int i = 0; i < n - 1; i++)
            add(8'(v >> (24 - 8 * i)), a85_pkg::ST_DATA, i == n - 2, i == n - 2);
        end
        clear();
        return;
      end
      if (halted || c <= a85_pkg::SPACE_CHAR || c >= a85_pkg::DEL_CHAR) return;
      effective++;
      if (c == a85_pkg::ZERO_CHAR && group_count == 0) begin
        for (int i = 0; i < 4; i++) add(8'd0, a85_pkg::ST_DATA, 1'b0, i == 3);
      end else if (c < a85_pkg::DIGIT_LOW || c > a85_pkg::DIGIT_HIGH) begin
        halted = 1'b1;
        add(8'd0, a85_pkg::ST_INVALID, 1'b0, 1'b1);
      end else begin
        group_value = group_value * a85_pkg::BASE85 + 32'(c - a85_pkg::DIGIT_LOW);
        group_count++;
        if (group_count == 5) begin
          for (int i = 0; i < 4; i++)
            add(8'(group_value >> (24 - 8 * i)), a85_pkg::ST_DATA, 1'b0, i == 3);
          group_count = '0;
          group_value = '0;
        end
      end
    endfunction

    function void check_result(a85_pkg::out_item_t got);
      a85_pkg::out_item_t want;
      results++;
      if (due_results.size() == 0) begin
        $error("result with nothing due: data_byte %0h status %0d", got.data_byte, got.status);
        faults++;
        return;
      end
      want = due_results.pop_front();
      if (got.data_byte !== want.data_byte) begin
        $error("data_byte expected %0h actual %0h", want.data_byte, got.data_byte);
        faults++;
      end
      if (got.status !== want.status) begin
        $error("status expected %0d actual %0d", want.status, got.status);
        faults++;
      end
      if (got.end_of_stream !== want.end_of_stream) begin
        $error("end_of_stream expected %0b actual %0b", want.end_of_stream,
               got.end_of_stream);
        faults++;
      end
      if (got.last !== want.last) begin
        $error("last expected %0b actual %0b", want.last, got.last);
        faults++;
      end
    endfunction
  endclass

  decode_tracker sb = new();

  ascii85_stream_decoder_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 38);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_request(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
    cycles++;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still due", cycles,
               sb.due_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_request(logic kind, logic [7:0] code);
    while (!steady && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_data.kind      <= kind;
    in_data.char_code <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_request(a85_pkg::KIND_CHAR, s[i]);
  endtask

  initial begin
    int         len;
    int         r;
    logic [7:0] c;

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    send_request(a85_pkg::KIND_END, 8'h00);
    send_text("z");
    // skip control, space, DEL and high bytes inside a group
    send_text("!");
    send_request(a85_pkg::KIND_CHAR, 8'h00);
    send_text("!");
    send_request(a85_pkg::KIND_CHAR, 8'hFF);
    send_text("!");
    send_request(a85_pkg::KIND_CHAR, a85_pkg::DEL_CHAR);
    send_text("!");
    send_request(a85_pkg::KIND_CHAR, a85_pkg::SPACE_CHAR);
    send_text("!");
    send_text("uu");
    send_request(a85_pkg::KIND_END, 8'hFF);
    send_text("u");
    send_request(a85_pkg::KIND_END, 8'h00);
    // 'z' inside a group halts; later characters drop until the end item
    send_text("!za");
    send_request(a85_pkg::KIND_END, 8'h5A);
    send_text("~");
    send_request(a85_pkg::KIND_END, 8'hA5);
    send_text("uuu");
    send_request(a85_pkg::KIND_END, 8'h00);

    while (sb.requests < 300) begin
      len = $urandom_range(1, 24);
      repeat (len) begin
        steady = (sb.requests >= 120 && sb.requests < 200);
        r = $urandom_range(0, 99);
        if (r < 70) begin
          c = 8'($urandom_range(a85_pkg::DIGIT_LOW, a85_pkg::DIGIT_HIGH));
        end else if (r < 74) begin
          c = ($urandom_range(0, 1) != 0) ? a85_pkg::DIGIT_LOW : a85_pkg::DIGIT_HIGH;
        end else if (r < 81) begin
          c = a85_pkg::ZERO_CHAR;
        end else if (r < 86) begin
          c = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 32))
                                          : 8'($urandom_range(127, 255));
        end else if (r < 90) begin
          c = 8'($urandom_range(118, 126));
        end else begin
          c = 8'($urandom_range(0, 255));
        end
        send_request(a85_pkg::KIND_CHAR, c);
      end
      send_request(a85_pkg::KIND_END, 8'($urandom_range(0, 255)));
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Decoded %0d requests (%0d not skipped) into %0d checked results",
             sb.requests, sb.effective, sb.results);
    $display("Streams covered groups, 'z', padding, lone and invalid characters, halting");
    if (sb.faults == 0 && sb.due_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> ascii85_stream_decoder_top.f
rtl/core/a85_pkg.sv
rtl/core/a85_front.sv
rtl/core/a85_job_queue.sv
rtl/core/a85_back.sv
rtl/core/ascii85_stream_decoder_top.sv
dv/testbench.sv
